// ===== rtl/core/tuner_pll_word_generator_defines.svh =====
// assertion macros shared by the tuner pll word generator rtl
// expects clk and arst_n in the scope of use
`ifndef TUNER_PLL_WORD_GENERATOR_DEFINES_SVH
`define TUNER_PLL_WORD_GENERATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define TPWG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define TPWG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tpwg_pkg.sv =====
// types, codes and tables for the tuner pll word generator
// no dependencies
`default_nettype none

package tpwg_pkg;

	localparam logic [1:0] OP_TUNE = 2'd0;
	localparam logic [1:0] OP_UP   = 2'd1;
	localparam logic [1:0] OP_DOWN = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_RANGE   = 3'd1;
	localparam logic [2:0] ST_NOTUNER = 3'd2;
	localparam logic [2:0] ST_NOFM    = 3'd3;
	localparam logic [2:0] ST_LOCALE  = 3'd4;

	localparam logic [1:0] REG_MAKER  = 2'd0;
	localparam logic [1:0] REG_LOCALE = 2'd1;
	localparam logic [1:0] REG_ADDR   = 2'd2;

	localparam logic [2:0] LOC_FM    = 3'd0;
	localparam logic [2:0] LOC_JAPAN = 3'd2;
	localparam logic [2:0] LOC_PAL   = 3'd3;
	localparam logic [2:0] LOC_SECAM = 3'd4;
	localparam logic [2:0] LOC_OTHER = 3'd5;

	localparam logic [2:0] MAKER_0    = 3'd0;
	localparam logic [2:0] MAKER_1    = 3'd1;
	localparam logic [2:0] MAKER_3    = 3'd3;
	localparam logic [2:0] MAKER_NONE = 3'd4;

	localparam logic [1:0] BAND_LOW  = 2'd0;
	localparam logic [1:0] BAND_MID  = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;

	localparam logic [31:0] FINE_STEP = 32'd62500;
	localparam logic [31:0] FM_LO     = 32'd64000000;
	localparam logic [31:0] FM_HI     = 32'd108000000;

	// intermediate frequencies in khz
	localparam logic [15:0] IFK_FM   = 16'd10700;
	localparam logic [15:0] IFK_NTSC = 16'd45750;
	localparam logic [15:0] IFK_M0   = 16'd58750;
	localparam logic [15:0] IFK_EURO = 16'd38900;

	localparam logic [15:0] WORD_FM_M1 = 16'h8ea5;
	localparam logic [15:0] WORD_FM_M3 = 16'h8204;
	localparam logic [7:0]  BAND_MARK  = 8'h40;

	// floor(x/125): x < 2^29 via ceil(2^36/125), x < 2^22 via ceil(2^29/125)
	localparam logic [29:0] RECIP_K1 = 30'd549755814;
	localparam logic [22:0] RECIP_K2 = 23'd4294968;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] midlo;
		logic [31:0] midhi;
		logic [31:0] hi;
	} edges_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  status;
		logic [15:0] word;
		logic [15:0] ifk;
		logic        mul2;
	} sel_t;

	function automatic edges_t band_edges(input logic euro, input logic [1:0] maker);
		edges_t e;
		unique case ({euro, maker})
			3'b000, 3'b100: e = '{32'd54000000, 32'd164000000, 32'd314000000, 32'd766000000};
			3'b001: e = '{32'd54000000, 32'd160000000, 32'd454000000, 32'd801250000};
			3'b010: e = '{32'd54000000, 32'd157250000, 32'd451250000, 32'd801250000};
			3'b011, 3'b111: e = '{32'd54000000, 32'd130000000, 32'd365000000, 32'd800000000};
			3'b101: e = '{32'd45750000, 32'd170000000, 32'd450000000, 32'd855250000};
			3'b110: e = '{32'd45750000, 32'd145250000, 32'd451250000, 32'd855250000};
		endcase
		return e;
	endfunction

	function automatic logic [15:0] band_word(input logic [1:0] band, input logic [1:0] maker,
		input logic secam_alt);
		logic [15:0] w;
		w = 16'h0000;
		if (secam_alt) begin
			case (band)
				BAND_LOW:  w = 16'h8ea7;
				BAND_MID:  w = 16'h8e97;
				BAND_HIGH: w = 16'h8e37;
				default:   w = 16'h0000;
			endcase
		end else begin
			case ({band, maker})
				{BAND_LOW, 2'd0}:  w = 16'hca04;
				{BAND_LOW, 2'd1}:  w = 16'h8ea0;
				{BAND_LOW, 2'd2}:  w = 16'h8e02;
				{BAND_LOW, 2'd3}:  w = 16'h8214;
				{BAND_MID, 2'd0}:  w = 16'hca02;
				{BAND_MID, 2'd1}:  w = 16'h8e90;
				{BAND_MID, 2'd2}:  w = 16'h8e04;
				{BAND_MID, 2'd3}:  w = 16'h8212;
				{BAND_HIGH, 2'd0}: w = 16'hca01;
				{BAND_HIGH, 2'd1}: w = 16'h8e30;
				{BAND_HIGH, 2'd2}: w = 16'h8e01;
				{BAND_HIGH, 2'd3}: w = 16'h8211;
				default:           w = 16'h0000;
			endcase
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tpwg_band_select.sv =====
// range check, band pick and band word lookup for one frequency
// depends on tpwg_pkg
`default_nettype none

module tpwg_band_select (
	input  wire logic [31:0]   freq,
	input  wire logic [2:0]    maker,
	input  wire logic [2:0]    locale,
	output tpwg_pkg::sel_t     sel
);
	import tpwg_pkg::*;

	edges_t     edges;
	logic       in_range;
	logic [1:0] band;

	always_comb begin
		edges = band_edges(locale >= LOC_PAL, maker[1:0]);
		in_range = !(freq < edges.lo || freq > edges.hi);
		priority if (freq < edges.midlo) begin
			band = BAND_LOW;
		end else if (freq < edges.midhi) begin
			band = BAND_MID;
		end else begin
			band = BAND_HIGH;
		end
	end

	always_comb begin
		sel = '0;
		sel.status = ST_OK;
		if (locale == LOC_FM) begin
			sel.ifk = IFK_FM;
			priority if (freq < FM_LO || freq > FM_HI) begin
				sel.status = ST_RANGE;
			end else if (maker == MAKER_1) begin
				sel.ok = 1'b1;
				sel.word = WORD_FM_M1;
			end else if (maker == MAKER_3) begin
				sel.ok = 1'b1;
				sel.word = WORD_FM_M3;
			end else begin
				sel.status = ST_NOFM;
			end
		end else if (locale <= LOC_SECAM) begin
			// tv locales
			sel.ifk = (locale >= LOC_PAL) ? IFK_EURO
				: ((maker == MAKER_0) ? IFK_M0 : IFK_NTSC);
			sel.mul2 = (maker == MAKER_0);
			priority if (maker >= MAKER_NONE) begin
				sel.status = ST_NOTUNER;
			end else if (!in_range) begin
				sel.status = ST_RANGE;
			end else begin
				sel.ok = 1'b1;
				sel.word = band_word(band, maker[1:0],
					(maker == MAKER_1) && (locale == LOC_SECAM));
			end
		end else begin
			sel.status = ST_LOCALE;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tuner_pll_word_generator.sv =====
// pipeline: request register s1, then s2, s3 and output stage s4; a good result gives
// a second beat once the first is taken, an error only one beat; throughput is limited
// by the last-frequency turnaround between s1 and s2 and by the two result beats of the output stage
// reset: async active low; clears valid flags, last frequency and config
// (maker 4, locale group 5, address 97)
`default_nettype none
`include "tuner_pll_word_generator_defines.svh"

module tuner_pll_word_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] target_hz,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [6:0]       bus_address,
	output logic [7:0]       first_byte,
	output logic [7:0]       second_byte,
	output logic             last
);
	import tpwg_pkg::*;

	// config registers
	logic [2:0] maker_q;
	logic [2:0] locale_q;
	logic [6:0] tuner_addr_q;
	logic       cfg_wr;

	// tuned frequency kept across requests
	logic [31:0] last_freq_q;

	// s1: request as accepted
	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [31:0] target_s1;
	logic [31:0] freq_next;
	logic        load_s2;
	logic        drop_s1;

	// s2: frequency, range check and first reciprocal multiply
	logic        valid_s2;
	logic [31:0] freq_s2;
	sel_t        sel;
	logic        up;
	logic [58:0] prod1;
	logic        adv_s2;
	logic        commit;

	// s3: khz sum and second reciprocal multiply
	logic        valid_s3;
	logic        ok_s3;
	logic [2:0]  status_s3;
	logic        up_s3;
	logic [15:0] word_s3;
	logic [19:0] khz_s3;
	logic [15:0] ifk_s3;
	logic        mul2_s3;
	logic [19:0] sum;
	logic [21:0] scaled;
	logic [44:0] prod2;
	logic [14:0] divisor;
	logic [7:0]  div_hi;
	logic [7:0]  div_lo;
	logic [7:0]  word_hi;
	logic [7:0]  word_lo;
	logic        adv_s3;

	// s4: output stage, one or two beats
	logic        valid_s4;
	logic        beat_s4;
	logic        ok_s4;
	logic [2:0]  status_s4;
	logic [7:0]  a_first_s4;
	logic [7:0]  a_second_s4;
	logic [7:0]  b_first_s4;
	logic [7:0]  b_second_s4;
	logic        out_fire;
	logic        done_s4;

	// ---------------------------------------------------------------
	// config port, always ready, writes land on the access phase
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maker_q      <= MAKER_NONE;
			locale_q     <= LOC_OTHER;
			tuner_addr_q <= 7'd97;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAKER:  maker_q      <= pwdata[2:0];
				REG_LOCALE: locale_q     <= pwdata[2:0];
				REG_ADDR:   tuner_addr_q <= pwdata[6:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAKER:  prdata = {29'd0, maker_q};
			REG_LOCALE: prdata = {29'd0, locale_q};
			REG_ADDR:   prdata = {25'd0, tuner_addr_q};
			default:    prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// s1: the step opcodes read last_freq_q, so s2 must be empty before
	// s1 moves on; that keeps one request ahead of the commit point
	// ---------------------------------------------------------------
	always_comb begin
		unique case (opcode_s1)
			OP_TUNE: freq_next = target_s1;
			OP_UP:   freq_next = last_freq_q + FINE_STEP;
			OP_DOWN: freq_next = last_freq_q - FINE_STEP;
			OP_NONE: freq_next = target_s1;
		endcase
	end

	// unused opcode just vanishes here
	assign drop_s1  = valid_s1 && (opcode_s1 == OP_NONE);
	assign load_s2  = valid_s1 && (opcode_s1 != OP_NONE) && !valid_s2;
	assign in_ready = !valid_s1 || drop_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			target_s1 <= target_hz;
		end
	end

	// ---------------------------------------------------------------
	// s2: band decision, direction and f/1000 by reciprocal
	// ---------------------------------------------------------------
	tpwg_band_select u_band_select (
		.freq   (freq_s2),
		.maker  (maker_q),
		.locale (locale_q),
		.sel    (sel)
	);

	assign up     = freq_s2 > last_freq_q;
	// f/1000 = (f>>3)/125
	assign prod1  = 59'(freq_s2[31:3]) * 59'(RECIP_K1);
	assign adv_s2 = valid_s2 && (!valid_s3 || adv_s3);
	// state commits as the request leaves s2, errors keep the old value
	assign commit = adv_s2 && sel.ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			last_freq_q <= 32'd0;
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (commit) begin
				last_freq_q <= freq_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			freq_s2 <= freq_next;
		end
	end

	// ---------------------------------------------------------------
	// s3: divisor = 16*mul*(f/1000 + if/1000)/1000 = 2*mul*sum/125
	// in range the sum stays below 2^20
	// ---------------------------------------------------------------
	assign sum     = khz_s3 + {4'd0, ifk_s3};
	assign scaled  = mul2_s3 ? {sum, 2'b00} : {1'b0, sum, 1'b0};
	assign prod2   = 45'(scaled) * 45'(RECIP_K2);
	assign divisor = prod2[43:29];
	assign div_hi  = {1'b0, divisor[14:8]};
	assign div_lo  = divisor[7:0];
	assign word_hi = word_s3[15:8] | BAND_MARK;
	assign word_lo = word_s3[7:0];
	assign adv_s3  = valid_s3 && (!valid_s4 || done_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s2) begin
			valid_s3 <= 1'b1;
		end else if (adv_s3) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ok_s3     <= sel.ok;
			status_s3 <= sel.status;
			up_s3     <= up;
			word_s3   <= sel.word;
			khz_s3    <= prod1[55:36];
			ifk_s3    <= sel.ifk;
			mul2_s3   <= sel.mul2;
		end
	end

	// ---------------------------------------------------------------
	// s4: holds both writes; divisor first when tuning upward,
	// band word first otherwise (equal frequency counts as not upward)
	// ---------------------------------------------------------------
	assign out_fire = valid_s4 && out_ready;
	// an error is a single beat
	assign done_s4  = out_fire && (beat_s4 || !ok_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			beat_s4  <= 1'b0;
		end else begin
			if (adv_s3) begin
				valid_s4 <= 1'b1;
			end else if (done_s4) begin
				valid_s4 <= 1'b0;
			end
			if (done_s4) begin
				beat_s4 <= 1'b0;
			end else if (out_fire) begin
				beat_s4 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			ok_s4       <= ok_s3;
			status_s4   <= status_s3;
			a_first_s4  <= up_s3 ? div_hi : word_hi;
			a_second_s4 <= up_s3 ? div_lo : word_lo;
			b_first_s4  <= up_s3 ? word_hi : div_hi;
			b_second_s4 <= up_s3 ? word_lo : div_lo;
		end
	end

	// error beats carry zero address and data
	assign out_valid   = valid_s4;
	assign status      = status_s4;
	assign bus_address = ok_s4 ? tuner_addr_q : 7'd0;
	assign first_byte  = !ok_s4 ? 8'd0 : (beat_s4 ? b_first_s4 : a_first_s4);
	assign second_byte = !ok_s4 ? 8'd0 : (beat_s4 ? b_second_s4 : a_second_s4);
	assign last        = !ok_s4 || beat_s4;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`TPWG_ASSERT_NXT(a_freq_hold, !commit, $stable(last_freq_q),
		"last frequency moved without a commit")
	`TPWG_ASSERT_IMP(a_err_one_beat, valid_s4 && !ok_s4, !beat_s4,
		"error request reached a second beat")
	`TPWG_ASSERT_NXT(a_second_beat, out_fire && !last, out_valid && last,
		"second write did not follow the first")
	`TPWG_ASSERT_NXT(a_s3_hold, valid_s3 && valid_s4 && !done_s4, valid_s3,
		"s3 request lost under output stall")

endmodule

`default_nettype wire
